// ===== sv/jsu_pkg.sv =====
// Package for the JSON string unescaper.
// Holds the scan phase type, the result kind and error codes and the result group
// structure that travels from the scanner to the output buffer. No dependencies.
`default_nettype none

package jsu_pkg;

   localparam int MaxResults = 4;

   typedef enum logic [3:0] {
      PH_PLAIN   = 4'd0,
      PH_ESC     = 4'd1,
      PH_HEX1    = 4'd2,
      PH_HEX2    = 4'd3,
      PH_HEX3    = 4'd4,
      PH_HEX4    = 4'd5,
      PH_WAIT_BS = 4'd6,
      PH_WAIT_U  = 4'd7,
      PH_LO1     = 4'd8,
      PH_LO2     = 4'd9,
      PH_LO3     = 4'd10,
      PH_LO4     = 4'd11
   } phase_type;

   localparam logic [1:0] KIND_DATA  = 2'd0;
   localparam logic [1:0] KIND_CLOSE = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [2:0] ERR_NONE         = 3'd0;
   localparam logic [2:0] ERR_INCOMPLETE   = 3'd0;
   localparam logic [2:0] ERR_UNKNOWN_ESC  = 3'd1;
   localparam logic [2:0] ERR_BAD_HEX      = 3'd2;
   localparam logic [2:0] ERR_MISSING_LOW  = 3'd3;
   localparam logic [2:0] ERR_BAD_LOW      = 3'd4;
   localparam logic [2:0] ERR_UNTERMINATED = 3'd5;

   // All results caused by one input item: up to four bytes, first in element 0.
   typedef struct packed {
      logic [MaxResults-1:0][7:0] bytes;
      logic [2:0]                 count;
      logic [1:0]                 kind;
      logic [2:0]                 code;
   } res_group_type;

endpackage

`default_nettype wire

// ===== sv/jsu_scan.sv =====
// Scanner for the JSON string unescaper: scan phase, hex accumulator and pending
// high surrogate, plus the logic that turns one input byte into its result group.
// Depends on jsu_pkg.
`default_nettype none

module jsu_scan
   import jsu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          accept,
   input  wire logic [7:0]    text_byte,
   output res_group_type      group
);

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SLASH  = 8'h2f;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_B      = 8'h62;
   localparam logic [7:0] CH_F      = 8'h66;
   localparam logic [7:0] CH_N      = 8'h6e;
   localparam logic [7:0] CH_R      = 8'h72;
   localparam logic [7:0] CH_T      = 8'h74;
   localparam logic [7:0] CH_U      = 8'h75;

   phase_type   phase_ff, phase_in;
   logic [15:0] accum_ff, accum_in;
   logic [9:0]  high_ff, high_in;

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic [15:0] accum_shift;
   logic [20:0] pair_cp;

   function automatic res_group_type single(input logic [7:0] b, input logic [1:0] k,
                                            input logic [2:0] e);
      res_group_type g;
      begin
         g          = '0;
         g.bytes[0] = b;
         g.count    = 3'd1;
         g.kind     = k;
         g.code     = e;
         return g;
      end
   endfunction

   function automatic res_group_type utf8_group(input logic [20:0] cp);
      res_group_type g;
      begin
         g      = '0;
         g.kind = KIND_DATA;
         g.code = ERR_NONE;
         if (cp <= 21'h7f) begin
            g.bytes[0] = cp[7:0];
            g.count    = 3'd1;
         end else if (cp <= 21'h7ff) begin
            g.bytes[0] = {3'b110, cp[10:6]};
            g.bytes[1] = {2'b10, cp[5:0]};
            g.count    = 3'd2;
         end else if (cp <= 21'hffff) begin
            g.bytes[0] = {4'b1110, cp[15:12]};
            g.bytes[1] = {2'b10, cp[11:6]};
            g.bytes[2] = {2'b10, cp[5:0]};
            g.count    = 3'd3;
         end else begin
            g.bytes[0] = {5'b11110, cp[20:18]};
            g.bytes[1] = {2'b10, cp[17:12]};
            g.bytes[2] = {2'b10, cp[11:6]};
            g.bytes[3] = {2'b10, cp[5:0]};
            g.count    = 3'd4;
         end
         return g;
      end
   endfunction

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (text_byte >= 8'h30 && text_byte <= 8'h39) begin
         hex_val = text_byte[3:0];
      end else if ((text_byte >= 8'h41 && text_byte <= 8'h46) ||
                   (text_byte >= 8'h61 && text_byte <= 8'h66)) begin
         hex_val = text_byte[3:0] + 4'd9;
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign accum_shift = {accum_ff[11:0], hex_val};
   assign pair_cp     = {1'b0, high_ff, accum_shift[9:0]} + 21'h10000;

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      accum_in = accum_ff;
      high_in  = high_ff;
      case (phase_ff)
         PH_ESC: begin
            phase_in = PH_PLAIN;
            if (text_byte == CH_U) begin
               accum_in = '0;
               phase_in = PH_HEX1;
            end else if (text_byte != CH_SLASH && text_byte != CH_BSLASH &&
                         text_byte != CH_QUOTE && text_byte != CH_T &&
                         text_byte != CH_R && text_byte != CH_N &&
                         text_byte != CH_F && text_byte != CH_B) begin
               accum_in = '0;
               high_in  = '0;
            end
         end
         PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
            if (!hex_ok) begin
               phase_in = PH_PLAIN;
               accum_in = '0;
               high_in  = '0;
            end else begin
               accum_in = accum_shift;
               case (phase_ff)
                  PH_HEX1: phase_in = PH_HEX2;
                  PH_HEX2: phase_in = PH_HEX3;
                  PH_HEX3: phase_in = PH_HEX4;
                  default: begin
                     if (accum_shift[15:10] == 6'b110110) begin
                        high_in  = accum_shift[9:0];
                        phase_in = PH_WAIT_BS;
                     end else begin
                        phase_in = PH_PLAIN;
                     end
                  end
               endcase
            end
         end
         PH_WAIT_BS: begin
            if (text_byte == CH_BSLASH) begin
               phase_in = PH_WAIT_U;
            end else begin
               phase_in = PH_PLAIN;
               accum_in = '0;
               high_in  = '0;
            end
         end
         PH_WAIT_U: begin
            if (text_byte == CH_U) begin
               accum_in = '0;
               phase_in = PH_LO1;
            end else begin
               phase_in = PH_PLAIN;
               accum_in = '0;
               high_in  = '0;
            end
         end
         PH_LO1, PH_LO2, PH_LO3, PH_LO4: begin
            if (!hex_ok) begin
               phase_in = PH_PLAIN;
               accum_in = '0;
               high_in  = '0;
            end else begin
               accum_in = accum_shift;
               case (phase_ff)
                  PH_LO1: phase_in = PH_LO2;
                  PH_LO2: phase_in = PH_LO3;
                  PH_LO3: phase_in = PH_LO4;
                  default: begin
                     phase_in = PH_PLAIN;
                     if (accum_shift[15:10] != 6'b110111) begin
                        accum_in = '0;
                        high_in  = '0;
                     end
                  end
               endcase
            end
         end
         default: begin
            phase_in = PH_PLAIN;
            if (text_byte == CH_NUL) begin
               accum_in = '0;
               high_in  = '0;
            end else if (text_byte == CH_BSLASH) begin
               phase_in = PH_ESC;
            end
         end
      endcase
   end

   // Result group for the byte at the input.
   always_comb begin
      group = '0;
      case (phase_ff)
         PH_ESC: begin
            case (text_byte)
               CH_SLASH:  group = single(CH_SLASH, KIND_DATA, ERR_NONE);
               CH_BSLASH: group = single(CH_BSLASH, KIND_DATA, ERR_NONE);
               CH_QUOTE:  group = single(CH_QUOTE, KIND_DATA, ERR_NONE);
               CH_T:      group = single(8'h09, KIND_DATA, ERR_NONE);
               CH_R:      group = single(8'h0d, KIND_DATA, ERR_NONE);
               CH_N:      group = single(8'h0a, KIND_DATA, ERR_NONE);
               CH_F:      group = single(8'h0c, KIND_DATA, ERR_NONE);
               CH_B:      group = single(8'h08, KIND_DATA, ERR_NONE);
               CH_U:      group = '0;
               CH_NUL:    group = single(8'h00, KIND_ERROR, ERR_INCOMPLETE);
               default:   group = single(8'h00, KIND_ERROR, ERR_UNKNOWN_ESC);
            endcase
         end
         PH_HEX1, PH_HEX2, PH_HEX3, PH_HEX4: begin
            if (!hex_ok) begin
               group = single(8'h00, KIND_ERROR, ERR_BAD_HEX);
            end else if (phase_ff == PH_HEX4 && accum_shift[15:10] != 6'b110110) begin
               group = utf8_group({5'd0, accum_shift});
            end
         end
         PH_WAIT_BS: begin
            if (text_byte != CH_BSLASH) begin
               group = single(8'h00, KIND_ERROR, ERR_MISSING_LOW);
            end
         end
         PH_WAIT_U: begin
            if (text_byte != CH_U) begin
               group = single(8'h00, KIND_ERROR, ERR_MISSING_LOW);
            end
         end
         PH_LO1, PH_LO2, PH_LO3, PH_LO4: begin
            if (!hex_ok) begin
               group = single(8'h00, KIND_ERROR, ERR_BAD_LOW);
            end else if (phase_ff == PH_LO4) begin
               if (accum_shift[15:10] != 6'b110111) begin
                  group = single(8'h00, KIND_ERROR, ERR_BAD_LOW);
               end else begin
                  group = utf8_group(pair_cp);
               end
            end
         end
         default: begin
            if (text_byte == CH_NUL) begin
               group = single(8'h00, KIND_ERROR, ERR_UNTERMINATED);
            end else if (text_byte == CH_QUOTE) begin
               group = single(8'h00, KIND_CLOSE, ERR_NONE);
            end else if (text_byte != CH_BSLASH) begin
               group = single(text_byte, KIND_DATA, ERR_NONE);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PLAIN;
         accum_ff <= '0;
         high_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         accum_ff <= accum_in;
         high_ff  <= high_in;
      end
   end

endmodule

`default_nettype wire

// ===== sv/jsu_obuf.sv =====
// Output buffer for the JSON string unescaper: holds the result group of one item
// and hands its results out one per cycle while rsp_ready is high. Depends on jsu_pkg.
`default_nettype none

module jsu_obuf
   import jsu_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          load,
   input  wire res_group_type group,
   output logic               can_load,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic [7:0]         rsp_out_byte,
   output logic [1:0]         rsp_kind,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_last
);

   logic [MaxResults-1:0][7:0] bytes_ff, bytes_in;
   logic [2:0]                 count_ff, count_in;
   logic [1:0]                 kind_ff, kind_in;
   logic [2:0]                 code_ff, code_in;
   logic                       pop;

   assign rsp_valid      = (count_ff != 3'd0);
   assign pop            = rsp_valid && rsp_ready;
   assign can_load       = (count_ff == 3'd0) || (count_ff == 3'd1 && rsp_ready);
   assign rsp_out_byte   = bytes_ff[0];
   assign rsp_kind       = kind_ff;
   assign rsp_error_code = code_ff;
   assign rsp_last       = (count_ff == 3'd1);

   always_comb begin
      bytes_in = bytes_ff;
      count_in = count_ff;
      kind_in  = kind_ff;
      code_in  = code_ff;
      if (load) begin
         bytes_in = group.bytes;
         count_in = group.count;
         kind_in  = group.kind;
         code_in  = group.code;
      end else if (pop) begin
         bytes_in = {8'h00, bytes_ff[MaxResults-1:1]};
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      bytes_ff <= bytes_in;
      kind_ff  <= kind_in;
      code_ff  <= code_in;
   end

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load && group.count != 3'd0 |=> rsp_valid)
      else $error("loaded results not presented");

   a_marker_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DATA |-> rsp_last && rsp_out_byte == 8'h00)
      else $error("marker or error result is not a lone zero-byte item");

   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      pop && count_ff > 3'd1 |=> rsp_valid && count_ff == $past(count_ff) - 3'd1)
      else $error("multi-byte result sequence lost or repeated a byte");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      load |-> count_ff == 3'd0 || (count_ff == 3'd1 && pop))
      else $error("new group loaded over pending results");

endmodule

`default_nettype wire

// ===== sv/json_string_unescape_utf8.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// Instantiates jsu_scan and jsu_obuf; uses jsu_pkg.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid/req_ready  | req_text_byte
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_out_byte, rsp_kind, rsp_error_code, rsp_last
//
// An item is decoded in the cycle it is accepted and its results are registered.
// Results leave rsp one per cycle while rsp_ready is high. An item with several results holds
// req_ready low until its last result waits; otherwise one item is taken every such cycle.
// req_ready follows rsp_ready combinationally while the last result is waiting.
// Reset returns the scanner to the plain text phase and empties the output buffer.
`default_nettype none

module json_string_unescape_utf8
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_text_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic [1:0]      rsp_kind,
   output logic [2:0]      rsp_error_code,
   output logic            rsp_last
);

   res_group_type group;
   logic          accept;
   logic          can_load;

   assign req_ready = can_load;
   assign accept    = req_valid && req_ready;

   jsu_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .text_byte (req_text_byte),
      .group     (group)
   );

   jsu_obuf u_obuf (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .group          (group),
      .can_load       (can_load),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_kind       (rsp_kind),
      .rsp_error_code (rsp_error_code),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for json_string_unescape_utf8.
// It drives JSON string body bytes, predicts the UTF-8 bytes, end markers and errors for each
// accepted item, and compares every result in order. It depends on jsu_pkg and the RTL only.

module tb;
   import jsu_pkg::*;

   localparam int CycleLimit  = 200000;
   localparam int RandomItems = 500;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [2:0] code;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       known;
      rsp_type    want;
   } item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic [1:0] rsp_kind;
   logic [2:0] rsp_error_code;
   logic       rsp_last;

   json_string_unescape_utf8 dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_text_byte (req_text_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_kind      (rsp_kind),
      .rsp_error_code(rsp_error_code),
      .rsp_last      (rsp_last)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Directed items; rows marked known carry the one result that the item must give.
   item_type plan [27] = '{
      {8'h00, 1'b1, 8'h00, KIND_ERROR, ERR_UNTERMINATED, 1'b1},
      {8'hff, 1'b1, 8'hff, KIND_DATA, ERR_NONE, 1'b1},
      {"\"", 1'b1, 8'h00, KIND_CLOSE, ERR_NONE, 1'b1},
      {"\\", 1'b0, 14'd0},
      {"n", 1'b1, 8'h0a, KIND_DATA, ERR_NONE, 1'b1},
      {"\\", 1'b0, 14'd0},
      {8'h00, 1'b1, 8'h00, KIND_ERROR, ERR_INCOMPLETE, 1'b1},
      {"\\", 1'b0, 14'd0},
      {"q", 1'b1, 8'h00, KIND_ERROR, ERR_UNKNOWN_ESC, 1'b1},
      {"\\", 1'b0, 14'd0},
      {"u", 1'b0, 14'd0},
      {"0", 1'b0, 14'd0},
      {"0", 1'b0, 14'd0},
      {"0", 1'b0, 14'd0},
      {"0", 1'b1, 8'h00, KIND_DATA, ERR_NONE, 1'b1},
      {"\\", 1'b0, 14'd0},
      {"u", 1'b0, 14'd0},
      {"d", 1'b0, 14'd0},
      {"8", 1'b0, 14'd0},
      {"3", 1'b0, 14'd0},
      {"d", 1'b0, 14'd0},
      {"\\", 1'b0, 14'd0},
      {"u", 1'b0, 14'd0},
      {"D", 1'b0, 14'd0},
      {"E", 1'b0, 14'd0},
      {"0", 1'b0, 14'd0},
      {"0", 1'b0, 14'd0}
   };

   logic [7:0] simple_esc [8] = '{"/", "\\", "\"", "t", "r", "n", "f", "b"};

   item_type feed [$];
   rsp_type  due_results [$];
   rsp_type  group_q [$];
   item_type cur;

   phase_type   scan_ph = PH_PLAIN;
   logic [15:0] accum = 16'h0000;
   logic [9:0]  high10 = 10'h000;

   int  errors = 0;
   int  taken = 0;
   int  cycles = 0;
   logic hold = 1'b0;
   wire calm = (taken >= 250) && (taken < 340);

   task automatic report_mismatch(input string msg);
      $display("mismatch at cycle %0d: %s", cycles, msg);
      errors++;
   endtask

   function automatic int nibble_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - 48;
      if (c >= "A" && c <= "F") return int'(c) - 55;
      if (c >= "a" && c <= "f") return int'(c) - 87;
      return -1;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] n);
      if (n < 4'd10) return 8'h30 + 8'(n);
      return ($urandom_range(1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
   endfunction

   function automatic logic [7:0] random_nonhex();
      logic [7:0] b;
      if ($urandom_range(3) == 0) return 8'h00;
      do b = 8'($urandom_range(255)); while (nibble_of(b) >= 0);
      return b;
   endfunction

   task automatic push_data(input logic [7:0] b);
      group_q.push_back({b, KIND_DATA, ERR_NONE, 1'b0});
   endtask

   task automatic fail_with(input logic [2:0] code);
      scan_ph = PH_PLAIN;
      accum   = 16'h0000;
      high10  = 10'h000;
      group_q.push_back({8'h00, KIND_ERROR, code, 1'b0});
   endtask

   task automatic emit_utf8(input logic [20:0] cp);
      if (cp <= 21'h7f) begin
         push_data(cp[7:0]);
      end else if (cp <= 21'h7ff) begin
         push_data({3'b110, cp[10:6]});
         push_data({2'b10, cp[5:0]});
      end else if (cp <= 21'hffff) begin
         push_data({4'b1110, cp[15:12]});
         push_data({2'b10, cp[11:6]});
         push_data({2'b10, cp[5:0]});
      end else begin
         push_data({5'b11110, cp[20:18]});
         push_data({2'b10, cp[17:12]});
         push_data({2'b10, cp[11:6]});
         push_data({2'b10, cp[5:0]});
      end
   endtask

   task automatic unescape_byte(input item_type it);
      logic [7:0] c;
      int         h;
      c = it.text_byte;
      h = nibble_of(c);
      group_q.delete();
      if (scan_ph == PH_ESC) begin
         scan_ph = PH_PLAIN;
         case (c)
            "/", "\\", "\"": push_data(c);
            "t": push_data(8'h09);
            "r": push_data(8'h0d);
            "n": push_data(8'h0a);
            "f": push_data(8'h0c);
            "b": push_data(8'h08);
            "u": begin
               accum   = 16'h0000;
               scan_ph = PH_HEX1;
            end
            8'h00: fail_with(ERR_INCOMPLETE);
            default: fail_with(ERR_UNKNOWN_ESC);
         endcase
      end else if (scan_ph >= PH_HEX1 && scan_ph <= PH_HEX4) begin
         if (h < 0) begin
            fail_with(ERR_BAD_HEX);
         end else begin
            accum = {accum[11:0], 4'(h)};
            if (scan_ph != PH_HEX4) begin
               scan_ph = phase_type'(scan_ph + 4'd1);
            end else if (accum[15:10] == 6'b110110) begin
               high10  = accum[9:0];
               scan_ph = PH_WAIT_BS;
            end else begin
               scan_ph = PH_PLAIN;
               emit_utf8({5'd0, accum});
            end
         end
      end else if (scan_ph == PH_WAIT_BS) begin
         if (c == "\\") scan_ph = PH_WAIT_U;
         else fail_with(ERR_MISSING_LOW);
      end else if (scan_ph == PH_WAIT_U) begin
         if (c == "u") begin
            accum   = 16'h0000;
            scan_ph = PH_LO1;
         end else begin
            fail_with(ERR_MISSING_LOW);
         end
      end else if (scan_ph >= PH_LO1 && scan_ph <= PH_LO4) begin
         if (h < 0) begin
            fail_with(ERR_BAD_LOW);
         end else begin
            accum = {accum[11:0], 4'(h)};
            if (scan_ph != PH_LO4) begin
               scan_ph = phase_type'(scan_ph + 4'd1);
            end else if (accum[15:10] != 6'b110111) begin
               fail_with(ERR_BAD_LOW);
            end else begin
               scan_ph = PH_PLAIN;
               emit_utf8(21'h10000 + {1'b0, high10, accum[9:0]});
            end
         end
      end else begin
         scan_ph = PH_PLAIN;
         if (c == 8'h00) fail_with(ERR_UNTERMINATED);
         else if (c == "\"") group_q.push_back({8'h00, KIND_CLOSE, ERR_NONE, 1'b0});
         else if (c == "\\") scan_ph = PH_ESC;
         else push_data(c);
      end
      if (group_q.size() != 0) group_q[group_q.size() - 1].last = 1'b1;
      if (it.known) begin
         due_results.push_back(it.want);
      end else begin
         foreach (group_q[i]) due_results.push_back(group_q[i]);
      end
   endtask

   task automatic push_feed(input logic [7:0] b);
      feed.push_back({b, 1'b0, 14'd0});
   endtask

   task automatic push_hex4(input logic [15:0] v);
      for (int i = 3; i >= 0; i--) push_feed(hex_char(v[4*i +: 4]));
   endtask

   task automatic push_partial_hex();
      int k;
      k = $urandom_range(3);
      repeat (k) push_feed(hex_char(4'($urandom_range(15))));
      push_feed(random_nonhex());
   endtask

   // Each group of bytes starts and ends in plain text, so it may follow any other.
   task automatic add_token();
      int          pick;
      logic [7:0]  b;
      logic [15:0] v;
      pick = $urandom_range(99);
      if (pick < 30) begin
         b = 8'($urandom_range(255, 1));
         if (b == "\\") b = 8'h5d;
         push_feed(b);
      end else if (pick < 40) begin
         push_feed("\"");
      end else if (pick < 55) begin
         push_feed("\\");
         push_feed(simple_esc[$urandom_range(7)]);
      end else if (pick < 73) begin
         case ($urandom_range(3))
            0: v = 16'($urandom_range(16'h7f));
            1: v = 16'($urandom_range(16'h7ff, 16'h80));
            2: begin
               v = 16'($urandom_range(16'hffff, 16'h800));
               if (v[15:10] == 6'b110110) v[10] = 1'b1;
            end
            default: v = 16'hdc00 | 16'($urandom_range(10'h3ff));
         endcase
         push_feed("\\");
         push_feed("u");
         push_hex4(v);
      end else if (pick < 85) begin
         push_feed("\\");
         push_feed("u");
         push_hex4(16'hd800 | 16'($urandom_range(10'h3ff)));
         push_feed("\\");
         push_feed("u");
         push_hex4(16'hdc00 | 16'($urandom_range(10'h3ff)));
      end else begin
         case ($urandom_range(5))
            0: begin
               push_feed("\\");
               push_feed(8'h00);
            end
            1: begin
               do b = 8'($urandom_range(255, 1));
               while (b inside {"/", "\\", "\"", "t", "r", "n", "f", "b", "u"});
               push_feed("\\");
               push_feed(b);
            end
            2: begin
               push_feed("\\");
               push_feed("u");
               push_partial_hex();
            end
            3: begin
               push_feed("\\");
               push_feed("u");
               push_hex4(16'hd800 | 16'($urandom_range(10'h3ff)));
               if ($urandom_range(1)) begin
                  b = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
                  if (b == "\\") b = 8'h00;
                  push_feed(b);
               end else begin
                  b = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom_range(255));
                  if (b == "u") b = "U";
                  push_feed("\\");
                  push_feed(b);
               end
            end
            4: begin
               push_feed("\\");
               push_feed("u");
               push_hex4(16'hd800 | 16'($urandom_range(10'h3ff)));
               push_feed("\\");
               push_feed("u");
               if ($urandom_range(1)) begin
                  push_partial_hex();
               end else begin
                  v = 16'($urandom_range(16'hffff));
                  if (v[15:10] == 6'b110111) v[15] = 1'b0;
                  push_hex4(v);
               end
            end
            default: push_feed(8'h00);
         endcase
      end
   endtask

   always @(posedge clock) begin : tick
      rsp_type want;
      cycles++;
      if (cycles >= CycleLimit) begin
         $display("FAILURE");
         $finish;
      end else if (reset) begin
         req_valid <= 1'b0;
         rsp_ready <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            unescape_byte(cur);
            taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               report_mismatch($sformatf("result byte %0h kind %0d with nothing expected",
                                         rsp_out_byte, rsp_kind));
            end else begin
               want = due_results.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  report_mismatch($sformatf("out_byte %0h, expected %0h",
                                            rsp_out_byte, want.out_byte));
               if (rsp_kind !== want.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d", rsp_kind, want.kind));
               if (rsp_error_code !== want.code)
                  report_mismatch($sformatf("error_code %0d, expected %0d",
                                            rsp_error_code, want.code));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %0b, expected %0b", rsp_last, want.last));
            end
         end
         if (!req_valid || req_ready) begin
            if (feed.size() != 0 && (calm || $urandom_range(99) >= 36)) begin
               cur = feed.pop_front();
               req_valid     <= 1'b1;
               req_text_byte <= cur.text_byte;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_ready <= !hold && (calm || $urandom_range(99) >= 36);
      end
   end

   // The receiver stops for a long stretch so that the block fills and holds off its input.
   initial begin
      while (taken < 80) @(posedge clock);
      hold <= 1'b1;
      repeat (80) @(posedge clock);
      hold <= 1'b0;
   end

   initial begin
      foreach (plan[i]) feed.push_back(plan[i]);
      while (feed.size() < $size(plan) + RandomItems) add_token();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (feed.size() != 0 || req_valid) @(posedge clock);
      while (due_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && due_results.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
